// File: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// File: rtl/ltc_pkg.sv
`timescale 1ns / 1ps
package ltc_pkg;
  localparam int TILE_EDGE_DEF = 256;
  localparam int MAX_SLOTS_DEF = 64;
  localparam int MAX_TILES_DEF = 16;
  localparam int TILE_COUNT = 256;

  localparam logic [1:0] FILL_HIT  = 2'd0;
  localparam logic [1:0] FILL_ZERO = 2'd1;
  localparam logic [1:0] FILL_LOAD = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_VICT,
    ST_UPD,
    ST_OUT
  } state_t;

  // Command to the LRU chain
  typedef struct packed {
    logic       touch;
    logic       append;
    logic [5:0] slot;
  } lru_cmd_t;
endpackage

// File: rtl/ltc_if.sv
`timescale 1ns / 1ps
interface ltc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  modport source (output valid, opcode, pixel_x, pixel_y, input ready);
  modport sink (input valid, opcode, pixel_x, pixel_y, output ready);
endinterface

interface ltc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [5:0]  slot;
  logic [17:0] byte_offset;
  logic [1:0]  fill_action;
  logic [7:0]  load_block;
  logic        write_back;
  logic [7:0]  write_back_block;
  modport source (output valid, status, slot, byte_offset, fill_action, load_block,
                  write_back, write_back_block, input ready);
  modport sink (input valid, status, slot, byte_offset, fill_action, load_block,
                write_back, write_back_block, output ready);
endinterface

// File: rtl/ltc_lru_cell.sv
`timescale 1ns / 1ps
// One position of the LRU order; position 0 is least recent
module ltc_lru_cell #(
  parameter int SW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          touch,
  input  logic          append,
  input  logic [SW-1:0] tslot,
  input  logic          is_last,
  input  logic          prev_shift,
  input  logic [SW-1:0] right_slot,
  output logic          shift,
  output logic [SW-1:0] slot
);
  logic hit;
  assign hit = (slot == tslot);
  // shifting starts at the matching entry and runs to the tail
  assign shift = touch && (prev_shift || hit);

  always_ff @(posedge clk) begin
    if (append && is_last) begin
      slot <= tslot;
    end else if (shift) begin
      slot <= is_last ? tslot : right_slot;
    end
    if (rst) begin
      slot <= '0;
    end
  end
endmodule

// File: rtl/ltc_lru_chain.sv
`timescale 1ns / 1ps
// Row of LRU cells; count of used cells limits the shift region
module ltc_lru_chain #(
  parameter int MAX_SLOTS = ltc_pkg::MAX_SLOTS_DEF,
  parameter int SW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  ltc_pkg::lru_cmd_t cmd,
  input  logic [SW:0]      used,
  output logic [SW-1:0]    head
);
  logic [SW-1:0] slots [MAX_SLOTS];
  logic [MAX_SLOTS:0] sh;
  logic [SW:0] tail;

  assign sh[0] = 1'b0;
  // append writes the new tail; touch shifts up to the old tail
  assign tail = cmd.append ? used : used - 1'b1;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic [SW-1:0] rs;
    logic inr;
    assign inr = (i < used);
    if (i + 1 < MAX_SLOTS) begin : g_r
      assign rs = slots[i+1];
    end else begin : g_e
      assign rs = '0;
    end
    ltc_lru_cell #(.SW(SW)) u_cell (
      .clk(clk), .rst(rst),
      .touch(cmd.touch && inr && !cmd.append),
      .append(cmd.append),
      .tslot(cmd.slot),
      .is_last(tail == (SW+1)'(i)),
      .prev_shift(sh[i]),
      .right_slot(rs),
      .shift(sh[i+1]),
      .slot(slots[i])
    );
  end

  assign head = slots[0];
endmodule

// File: rtl/lru_tile_cache_controller.sv
`timescale 1ns / 1ps
// LRU write-back tile cache controller.
// Input channel in_item: one pixel access (opcode, pixel_x, pixel_y).
// Output channel out_item: one result per access (status, slot, byte offset,
// fill command and write-back command).
// Configuration: cfg_we / cfg_index / cfg_data write one of four registers
// (image width, image height, bytes per pixel, cached tile limit).
// For an access inside the image the item passes a tile table read, a victim
// table read and a table and LRU update into the result register; an access
// outside the image goes straight into the result register. One item is in
// flight at a time, so a new item is taken only after the last result has
// left the output register; the tile tables are single-port memories read
// then written.
// The LRU order is a row of cells; a touch moves the touched slot to the tail.
// Reset clears state, valid bits and counters at once; no clearing pass.
// When the receiver stalls the result holds in the output register and no
// new item is taken until it leaves.
module lru_tile_cache_controller #(
  parameter int TILE_EDGE = ltc_pkg::TILE_EDGE_DEF,
  parameter int MAX_SLOTS = ltc_pkg::MAX_SLOTS_DEF,
  parameter int MAX_TILES_PER_SIDE = ltc_pkg::MAX_TILES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ltc_in_if.sink      in_item,
  ltc_out_if.source   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int SW = $clog2(MAX_SLOTS);
  localparam int EB = $clog2(TILE_EDGE);

  logic [12:0] image_width, image_height;
  logic [2:0]  bytes_per_pixel;
  logic [6:0]  cached_tile_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd4096;
      image_height <= 13'd4096;
      bytes_per_pixel <= 3'd1;
      cached_tile_limit <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ltc_pkg::REG_WIDTH:  image_width <= cfg_data;
        ltc_pkg::REG_HEIGHT: image_height <= cfg_data;
        ltc_pkg::REG_BPP:    bytes_per_pixel <= cfg_data[2:0];
        ltc_pkg::REG_LIMIT:  cached_tile_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Per-tile valid bits in flip-flops; payload in memories
  logic [255:0] res_v, dirty, back_v;
  logic [SW-1:0] res_mem [256];
  logic [7:0]    back_mem [256];
  logic [7:0]    owner_mem [MAX_SLOTS];

  ltc_pkg::state_t state, state_next;
  logic        op;
  logic [11:0] px, py;
  logic [7:0]  tile, vtile;
  logic [SW:0] used;
  logic [8:0]  appended;
  logic [SW-1:0] rd_res, head, sel;
  logic [7:0]  rd_back, rd_vback, rd_owner;
  logic        oob;
  logic [6:0]  lim;
  logic        hit, take_free;
  ltc_pkg::lru_cmd_t cmd;

  // Output register
  logic        ov, o_status, o_wb;
  logic [SW-1:0] o_slot;
  logic [17:0] o_off;
  logic [1:0]  o_fill;
  logic [7:0]  o_lb, o_wbb;

  assign in_item.ready = (state == ltc_pkg::ST_IDLE) && !ov;

  // Tile coordinates and bounds check
  logic [11:0] tcol, trow;
  assign tcol = 12'(in_item.pixel_x >> EB);
  assign trow = 12'(in_item.pixel_y >> EB);
  always_comb begin
    oob = ({1'b0, in_item.pixel_x} >= image_width) || ({1'b0, in_item.pixel_y} >= image_height)
      || (tcol >= 12'(MAX_TILES_PER_SIDE)) || (trow >= 12'(MAX_TILES_PER_SIDE));
  end

  always_comb begin
    lim = cached_tile_limit;
    if (lim == 7'd0) lim = 7'd1;
    if (lim > 7'(MAX_SLOTS)) lim = 7'(MAX_SLOTS);
  end

  logic [2:0] bpp;
  always_comb begin
    bpp = bytes_per_pixel;
    if (bpp == 3'd0) bpp = 3'd1;
    if (bpp > 3'd4) bpp = 3'd4;
  end

  assign hit = res_v[tile];
  assign take_free = ({1'b0, used} < {1'b0, lim[SW:0]}) && (7'(used) < lim);
  assign sel = hit ? rd_res : (take_free ? used[SW-1:0] : head);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ltc_pkg::ST_IDLE: if (in_item.valid && in_item.ready && !oob)
        state_next = ltc_pkg::ST_LOOK;
      ltc_pkg::ST_LOOK: state_next = ltc_pkg::ST_VICT;
      ltc_pkg::ST_VICT: state_next = ltc_pkg::ST_UPD;
      ltc_pkg::ST_UPD: begin
        cmd.slot = sel;
        cmd.touch = 1'b1;
        cmd.append = !hit && take_free;
        state_next = ltc_pkg::ST_OUT;
      end
      ltc_pkg::ST_OUT: state_next = ltc_pkg::ST_IDLE;
      default: state_next = ltc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ltc_pkg::ST_IDLE;
    else state <= state_next;
  end

  ltc_lru_chain #(.MAX_SLOTS(MAX_SLOTS), .SW(SW)) u_chain (
    .clk(clk), .rst(rst), .cmd(cmd), .used(used), .head(head)
  );

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      op <= in_item.opcode;
      px <= in_item.pixel_x;
      py <= in_item.pixel_y;
      tile <= 8'(trow * 12'(MAX_TILES_PER_SIDE) + tcol);
    end
  end

  // Memory reads: tile tables and owner of the victim slot, then the victim's back entry
  always_ff @(posedge clk) begin
    if (state == ltc_pkg::ST_LOOK) begin
      rd_res <= res_mem[tile];
      rd_back <= back_mem[tile];
      rd_owner <= owner_mem[head];
    end
    if (state == ltc_pkg::ST_VICT) begin
      vtile <= rd_owner;
      rd_vback <= back_mem[rd_owner];
    end
  end

  // Update tables, counters and the output register
  logic evict, vdirty, need_app;
  assign evict = !hit && !take_free;
  assign vdirty = evict && dirty[vtile];
  assign need_app = vdirty && !back_v[vtile];

  always_ff @(posedge clk) begin
    if (state == ltc_pkg::ST_UPD) begin
      if (!hit) begin
        owner_mem[sel] <= tile;
        res_mem[tile] <= sel;
      end
      if (need_app) back_mem[vtile] <= appended[7:0];
      o_slot <= sel;
      o_off <= 18'(bpp) * 18'({py[EB-1:0], px[EB-1:0]});
      o_fill <= hit ? ltc_pkg::FILL_HIT :
                (back_v[tile] ? ltc_pkg::FILL_LOAD : ltc_pkg::FILL_ZERO);
      o_lb <= (!hit && back_v[tile]) ? rd_back : 8'd0;
      o_wb <= vdirty;
      o_wbb <= vdirty ? (need_app ? appended[7:0] : rd_vback) : 8'd0;
      o_status <= 1'b0;
    end else if (in_item.valid && in_item.ready && oob) begin
      o_status <= 1'b1;
      o_slot <= '0; o_off <= '0; o_fill <= ltc_pkg::FILL_HIT;
      o_lb <= '0; o_wb <= 1'b0; o_wbb <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= '0; dirty <= '0; back_v <= '0;
      used <= '0; appended <= '0; ov <= 1'b0;
    end else begin
      if (out_item.valid && out_item.ready) ov <= 1'b0;
      if (in_item.valid && in_item.ready && oob) ov <= 1'b1;
      if (state == ltc_pkg::ST_UPD) begin
        ov <= 1'b1;
        if (evict) begin
          res_v[vtile] <= 1'b0;
          if (vdirty) dirty[vtile] <= 1'b0;
          if (need_app) begin
            back_v[vtile] <= 1'b1;
            appended <= appended + 9'd1;
          end
        end
        if (!hit && take_free) used <= used + 1'b1;
        if (!hit) res_v[tile] <= 1'b1;
        if (op) dirty[tile] <= 1'b1;
      end
    end
  end

  assign out_item.valid = ov;
  assign out_item.status = o_status;
  assign out_item.slot = 6'(o_slot);
  assign out_item.byte_offset = o_off;
  assign out_item.fill_action = o_fill;
  assign out_item.load_block = o_lb;
  assign out_item.write_back = o_wb;
  assign out_item.write_back_block = o_wbb;
endmodule

// File: rtl/ltc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ltc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       status,
  input logic [1:0] fill_action,
  input logic       write_back,
  input logic [7:0] write_back_block,
  input logic [7:0] load_block
);
  `CHK_IMPL(a_no_take_busy, clk, rst, out_valid, !in_ready)
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(fill_action))
  `CHK_IMPL(a_oob_zero, clk, rst, out_valid && status, fill_action == ltc_pkg::FILL_HIT && !write_back)
  `CHK_IMPL(a_hit_clean, clk, rst, out_valid && fill_action == ltc_pkg::FILL_HIT, !write_back && write_back_block == 8'd0 && load_block == 8'd0)
endmodule

bind lru_tile_cache_controller ltc_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_item.valid), .in_ready(in_item.ready),
  .out_valid(out_item.valid), .out_ready(out_item.ready),
  .status(out_item.status), .fill_action(out_item.fill_action),
  .write_back(out_item.write_back), .write_back_block(out_item.write_back_block),
  .load_block(out_item.load_block)
);
